FILE: design/cgp_window_filter_eval_defines.svh
// ----------------------------------------------------------------------------
// cgp window filter assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef CGP_WINDOW_FILTER_EVAL_DEFINES_SVH
`define CGP_WINDOW_FILTER_EVAL_DEFINES_SVH

// same-cycle implication
`define CGPWF_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define CGPWF_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/cgpwf_pkg.sv
// ----------------------------------------------------------------------------
// cgpwf_pkg
// shared types, field layout, function codes and the node operation
// ----------------------------------------------------------------------------
package cgpwf_pkg;

  // field widths fixed by the word layout
  localparam int PIXEL_W       = 8;
  localparam int SEL_W         = 6;
  localparam int ADDR_W        = 6;
  localparam int GENE_W        = 16;
  localparam int FUNC_W        = 4;
  localparam int WINDOW_INPUTS = 9;

  // gene word layout
  localparam int SEL_A_LSB = 10;
  localparam int SEL_B_LSB = 4;

  // default grid size
  localparam int DEF_NODE_COLUMNS = 8;
  localparam int DEF_NODE_ROWS    = 4;

  // slave tdata layout
  localparam int TD_ADDR_LSB = 0;
  localparam int TD_WORD_LSB = TD_ADDR_LSB + ADDR_W;
  localparam int TD_PIX_LSB  = TD_WORD_LSB + GENE_W;
  localparam int TD_BITS     = TD_PIX_LSB + WINDOW_INPUTS * PIXEL_W;
  localparam int S_TDATA_W   = ((TD_BITS + 7) / 8) * 8;

  // item kinds
  localparam logic KIND_GENE   = 1'b0;
  localparam logic KIND_WINDOW = 1'b1;

  // node function codes
  localparam logic [FUNC_W-1:0] FN_PASS_A = 4'd0;
  localparam logic [FUNC_W-1:0] FN_MAX    = 4'd1;
  localparam logic [FUNC_W-1:0] FN_MIN    = 4'd2;
  localparam logic [FUNC_W-1:0] FN_ADD    = 4'd3;
  localparam logic [FUNC_W-1:0] FN_SUB_AB = 4'd4;
  localparam logic [FUNC_W-1:0] FN_SUB_BA = 4'd5;
  localparam logic [FUNC_W-1:0] FN_AND    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_OR     = 4'd7;
  localparam logic [FUNC_W-1:0] FN_MUL    = 4'd8;
  localparam logic [FUNC_W-1:0] FN_XOR    = 4'd9;
  localparam logic [FUNC_W-1:0] FN_NOT_A  = 4'd10;
  localparam logic [FUNC_W-1:0] FN_NOT_B  = 4'd11;
  localparam logic [FUNC_W-1:0] FN_ANDN   = 4'd12;
  localparam logic [FUNC_W-1:0] FN_NAND   = 4'd13;
  localparam logic [FUNC_W-1:0] FN_NOR    = 4'd14;
  localparam logic [FUNC_W-1:0] FN_ONES   = 4'd15;

  localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

  // item fields that travel with each pipeline stage
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [GENE_W-1:0] word;
  } item_t;

  // one node operation, wrapping arithmetic
  function automatic logic [PIXEL_W-1:0] node_op(input logic [FUNC_W-1:0] fn,
                                                 input logic [PIXEL_W-1:0] a,
                                                 input logic [PIXEL_W-1:0] b);
    logic [2*PIXEL_W-1:0] prod;
    logic [PIXEL_W-1:0]   r;
    prod = a * b;
    case (fn)
      FN_PASS_A: r = a;
      FN_MAX:    r = (a > b) ? a : b;
      FN_MIN:    r = (a < b) ? a : b;
      FN_ADD:    r = a + b;
      FN_SUB_AB: r = a - b;
      FN_SUB_BA: r = b - a;
      FN_AND:    r = a & b;
      FN_OR:     r = a | b;
      FN_MUL:    r = prod[PIXEL_W-1:0];
      FN_XOR:    r = a ^ b;
      FN_NOT_A:  r = ~a;
      FN_NOT_B:  r = ~b;
      FN_ANDN:   r = a & ~b;
      FN_NAND:   r = ~(a & b);
      FN_NOR:    r = ~(a | b);
      default:   r = PIXEL_MAX;
    endcase
    return r;
  endfunction

endpackage

FILE: design/cgpwf_stage.sv
// ----------------------------------------------------------------------------
// cgpwf_stage
// one pipeline stage: holds the gene of node NODE_IDX, evaluates that node on
// the incoming value vector and registers the vector with the node appended
// ----------------------------------------------------------------------------
module cgpwf_stage
  import cgpwf_pkg::*;
#(
  parameter int NODE_IDX    = 0,
  parameter int VALUE_COUNT = WINDOW_INPUTS + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  item_t                                in_item,
  input  logic [VALUE_COUNT-1:0][PIXEL_W-1:0]  in_vals,
  output logic                                 out_valid,
  output item_t                                out_item,
  output logic [VALUE_COUNT-1:0][PIXEL_W-1:0]  out_vals
);

  // values visible to this node: pixels and earlier nodes
  localparam int LIMIT = WINDOW_INPUTS + NODE_IDX;

  logic [GENE_W-1:0]                  gene;
  logic [SEL_W-1:0]                   sel_a;
  logic [SEL_W-1:0]                   sel_b;
  logic [FUNC_W-1:0]                  fn;
  logic [PIXEL_W-1:0]                 opd_a;
  logic [PIXEL_W-1:0]                 opd_b;
  logic [VALUE_COUNT-1:0][PIXEL_W-1:0] vals_next;

  // gene register, written when a gene word for this node passes
  always_ff @(posedge clk) begin
    if (en && in_valid && in_item.kind == KIND_GENE && int'(in_item.addr) == NODE_IDX) begin
      gene <= in_item.word;
    end
  end

  assign sel_a = gene[SEL_A_LSB +: SEL_W];
  assign sel_b = gene[SEL_B_LSB +: SEL_W];
  assign fn    = gene[FUNC_W-1:0];

  // operand select, anything at or past this node reads zero
  always_comb begin
    opd_a = '0;
    opd_b = '0;
    for (int j = 0; j < LIMIT; j++) begin
      if (int'(sel_a) == j) opd_a = in_vals[j];
      if (int'(sel_b) == j) opd_b = in_vals[j];
    end
  end

  // append node value
  always_comb begin
    vals_next = in_vals;
    vals_next[LIMIT] = node_op(fn, opd_a, opd_b);
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= in_item;
      out_vals <= vals_next;
    end
  end

endmodule

FILE: design/cgp_window_filter_eval.sv
// ----------------------------------------------------------------------------
// cgp_window_filter_eval
// cartesian genetic programming filter on one 3x3 pixel window per word
//
//   channel | dir | handshake             | contents
//   s_axis  | in  | tvalid tready         | tuser kind, tdata gene or window
//   m_axis  | out | tvalid tready         | tdata result pixel
//
// one word accepted per cycle unless a stalled master holds the pipeline;
// one register stage per node followed by the output select register.
// gene words ride the pipeline and update each node's gene as they pass, so
// order against windows is kept.
// rst is synchronous; it clears stage valids, the output valid and the output selector only.
// a stalled master freezes every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "cgp_window_filter_eval_defines.svh"

module cgp_window_filter_eval
  import cgpwf_pkg::*;
#(
  parameter int NODE_COLUMNS = DEF_NODE_COLUMNS,
  parameter int NODE_ROWS    = DEF_NODE_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [5:0] gene_addr, [21:6] gene_word, [29:22] pix_0 .. [93:86] pix_8, pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] result_pixel
  output logic [PIXEL_W-1:0]   m_axis_tdata
);

  localparam int NODE_COUNT  = NODE_COLUMNS * NODE_ROWS;
  localparam int VALUE_COUNT = WINDOW_INPUTS + NODE_COUNT;

  logic                                en;
  logic                                stg_valid [NODE_COUNT+1];
  item_t                               stg_item  [NODE_COUNT+1];
  logic [VALUE_COUNT-1:0][PIXEL_W-1:0] stg_vals  [NODE_COUNT+1];
  logic [SEL_W-1:0]                    out_sel;
  logic [PIXEL_W-1:0]                  pick;
  logic                                last_valid;
  item_t                               last_item;
  logic [VALUE_COUNT-1:0][PIXEL_W-1:0] last_vals;

  // whole pipeline advances when the output register can move
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack incoming word
  assign stg_valid[0]     = s_axis_tvalid;
  assign stg_item[0].kind = s_axis_tuser;
  assign stg_item[0].addr = s_axis_tdata[TD_ADDR_LSB +: ADDR_W];
  assign stg_item[0].word = s_axis_tdata[TD_WORD_LSB +: GENE_W];

  // pixels first, node slots start at zero
  always_comb begin
    stg_vals[0] = '0;
    for (int k = 0; k < WINDOW_INPUTS; k++) begin
      stg_vals[0][k] = s_axis_tdata[TD_PIX_LSB + k*PIXEL_W +: PIXEL_W];
    end
  end

  // one stage per node, in node order
  for (genvar n = 0; n < NODE_COUNT; n++) begin : g_node
    cgpwf_stage #(
      .NODE_IDX    (n),
      .VALUE_COUNT (VALUE_COUNT)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stg_valid[n]),
      .in_item   (stg_item[n]),
      .in_vals   (stg_vals[n]),
      .out_valid (stg_valid[n+1]),
      .out_item  (stg_item[n+1]),
      .out_vals  (stg_vals[n+1])
    );
  end

  assign last_valid = stg_valid[NODE_COUNT];
  assign last_item  = stg_item[NODE_COUNT];
  assign last_vals  = stg_vals[NODE_COUNT];

  // output selector, written by the gene word addressed one past the last node
  always_ff @(posedge clk) begin
    if (rst) begin
      out_sel <= '0;
    end else if (en && last_valid && last_item.kind == KIND_GENE &&
                 int'(last_item.addr) == NODE_COUNT) begin
      out_sel <= last_item.word[SEL_W-1:0];
    end
  end

  // final select, out of range reads zero
  always_comb begin
    pick = '0;
    for (int j = 0; j < VALUE_COUNT; j++) begin
      if (int'(out_sel) == j) pick = last_vals[j];
    end
  end

  // output register valid, only windows produce a word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= last_valid && last_item.kind == KIND_WINDOW;
    end
  end

  // output register data
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= pick;
    end
  end

  // checks
  `CGPWF_ASSERT_NOW(a_rise_from_window, $rose(m_axis_tvalid), $past(last_valid && last_item.kind == KIND_WINDOW), "output word without a window")
  `CGPWF_ASSERT_NEXT(a_gene_no_output, en && last_valid && last_item.kind == KIND_GENE, !m_axis_tvalid, "gene word produced an output")
  `CGPWF_ASSERT_NEXT(a_out_sel_write, en && last_valid && last_item.kind == KIND_GENE && int'(last_item.addr) == NODE_COUNT, out_sel == $past(last_item.word[SEL_W-1:0]), "output selector not updated")
  `CGPWF_ASSERT_NEXT(a_stall_holds, !en, $stable(last_valid) && $stable(last_item), "last stage moved during stall")

endmodule

FILE: sim/cgp_window_filter_eval_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cgp_window_filter_eval_checker
// follows the chromosome from accepted gene words, predicts the result pixel
// of every accepted window and compares the master side against it in order
// ----------------------------------------------------------------------------
module cgp_window_filter_eval_checker
  import cgpwf_pkg::*;
#(
  parameter int NODE_COUNT = DEF_NODE_COLUMNS * DEF_NODE_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // [5:0] gene_addr, [21:6] gene_word, [29:22] pix_0 .. [93:86] pix_8, pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] result_pixel
  input  logic [PIXEL_W-1:0]   m_axis_tdata,
  output int                   fail_count,
  output int                   outstanding
);

  localparam int VALUE_COUNT = WINDOW_INPUTS + NODE_COUNT;

  logic [GENE_W-1:0]  chromosome [NODE_COUNT];
  logic [SEL_W-1:0]   out_select;
  logic [PIXEL_W-1:0] expected_pixels [$];

  // one node, 8-bit results with wraparound
  function automatic logic [PIXEL_W-1:0] node_value(input logic [FUNC_W-1:0] fn,
                                                    input logic [PIXEL_W-1:0] a,
                                                    input logic [PIXEL_W-1:0] b);
    logic [2*PIXEL_W-1:0] wide;
    logic [PIXEL_W-1:0]   v;
    wide = {{PIXEL_W{1'b0}}, a} * {{PIXEL_W{1'b0}}, b};
    case (fn)
      FN_PASS_A: v = a;
      FN_MAX:    v = (a >= b) ? a : b;
      FN_MIN:    v = (a <= b) ? a : b;
      FN_ADD:    v = a + b;
      FN_SUB_AB: v = a - b;
      FN_SUB_BA: v = b - a;
      FN_AND:    v = a & b;
      FN_OR:     v = a | b;
      FN_MUL:    v = wide[PIXEL_W-1:0];
      FN_XOR:    v = a ^ b;
      FN_NOT_A:  v = ~a;
      FN_NOT_B:  v = ~b;
      FN_ANDN:   v = a & ~b;
      FN_NAND:   v = ~(a & b);
      FN_NOR:    v = ~(a | b);
      default:   v = PIXEL_MAX;
    endcase
    return v;
  endfunction

  // run the whole node grid on one window and pick the selected value
  function automatic logic [PIXEL_W-1:0] filter_window(
      input logic [WINDOW_INPUTS*PIXEL_W-1:0] pix);
    logic [PIXEL_W-1:0] vals [VALUE_COUNT];
    logic [GENE_W-1:0]  g;
    logic [SEL_W-1:0]   sa;
    logic [SEL_W-1:0]   sb;
    logic [PIXEL_W-1:0] a;
    logic [PIXEL_W-1:0] b;
    for (int k = 0; k < WINDOW_INPUTS; k++) vals[k] = pix[k*PIXEL_W +: PIXEL_W];
    for (int n = 0; n < NODE_COUNT; n++) begin
      g  = chromosome[n];
      sa = g[SEL_A_LSB +: SEL_W];
      sb = g[SEL_B_LSB +: SEL_W];
      // self, forward and out of range selectors read zero
      a = (sa < WINDOW_INPUTS + n) ? vals[sa] : '0;
      b = (sb < WINDOW_INPUTS + n) ? vals[sb] : '0;
      vals[WINDOW_INPUTS + n] = node_value(g[FUNC_W-1:0], a, b);
    end
    return (out_select < VALUE_COUNT) ? vals[out_select] : '0;
  endfunction

  always @(posedge clk) begin
    logic [ADDR_W-1:0]  addr;
    logic [GENE_W-1:0]  word;
    logic [PIXEL_W-1:0] want;
    if (rst) begin
      out_select = '0;
      expected_pixels.delete();
      fail_count = 0;
    end else begin
      // accepted input word: gene update or new prediction
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KIND_WINDOW) begin
          expected_pixels.push_back(
            filter_window(s_axis_tdata[TD_PIX_LSB +: WINDOW_INPUTS*PIXEL_W]));
        end else begin
          addr = s_axis_tdata[TD_ADDR_LSB +: ADDR_W];
          word = s_axis_tdata[TD_WORD_LSB +: GENE_W];
          if (addr < NODE_COUNT) chromosome[addr] = word;
          else if (addr == NODE_COUNT) out_select = word[SEL_W-1:0];
        end
      end
      // accepted result word against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result pixel %0d with no window pending", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata !== want) begin
            if (fail_count < 10)
              $display("%0t: result pixel %0d, expected %0d", $time, m_axis_tdata, want);
            fail_count++;
          end
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

FILE: sim/cgp_window_filter_eval_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cgp_window_filter_eval_tb
// loads chromosomes through gene words and streams pixel windows through the
// filter; a directed chromosome covers every node function and the zero-read
// selector cases, then random chromosomes with random windows follow, both
// sides idling at random; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module cgp_window_filter_eval_tb;
  import cgpwf_pkg::*;

  localparam int NODE_COUNT   = DEF_NODE_COLUMNS * DEF_NODE_ROWS;
  localparam int VALUE_COUNT  = WINDOW_INPUTS + NODE_COUNT;
  localparam int SEL_TOP      = (1 << SEL_W) - 1;
  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = NODE_COUNT + 16;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef logic [WINDOW_INPUTS*PIXEL_W-1:0] window_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [5:0] gene_addr, [21:6] gene_word, [29:22] pix_0 .. [93:86] pix_8, pad
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // [0] kind
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [7:0] result_pixel
  logic [PIXEL_W-1:0]   m_axis_tdata;

  int fail_count;
  int outstanding;
  int item_count;
  bit no_idle;

  cgp_window_filter_eval #(
    .NODE_COLUMNS(DEF_NODE_COLUMNS),
    .NODE_ROWS   (DEF_NODE_ROWS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  cgp_window_filter_eval_checker #(
    .NODE_COUNT(NODE_COUNT)
  ) result_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("cgp_window_filter_eval test failed");
    $finish;
  end

  // result side backpressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 6);
    end
  end

  // one word on the slave side, with random idle cycles ahead of it
  task automatic send_word(input logic kind, input logic [ADDR_W-1:0] addr,
                           input logic [GENE_W-1:0] word, input window_t pix);
    logic [S_TDATA_W-1:0] data;
    data = '0;
    data[TD_ADDR_LSB +: ADDR_W] = addr;
    data[TD_WORD_LSB +: GENE_W] = word;
    data[TD_PIX_LSB +: WINDOW_INPUTS*PIXEL_W] = pix;
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    // ignored gene addresses do not count
    if (kind == KIND_WINDOW || addr <= NODE_COUNT) item_count++;
  endtask

  function automatic window_t rand_window();
    window_t w;
    for (int k = 0; k < WINDOW_INPUTS; k++) begin
      case ($urandom_range(0, 19))
        0:       w[k*PIXEL_W +: PIXEL_W] = '0;
        1:       w[k*PIXEL_W +: PIXEL_W] = PIXEL_MAX;
        default: w[k*PIXEL_W +: PIXEL_W] = PIXEL_W'($urandom);
      endcase
    end
    return w;
  endfunction

  // gene and window words carry random bits in the fields they do not use
  task automatic send_gene(input logic [ADDR_W-1:0] addr, input logic [GENE_W-1:0] word);
    send_word(KIND_GENE, addr, word, rand_window());
  endtask

  task automatic send_window(input window_t pix);
    send_word(KIND_WINDOW, ADDR_W'($urandom), GENE_W'($urandom), pix);
  endtask

  // operand selector, mostly legal with a bias toward recent nodes
  function automatic logic [SEL_W-1:0] rand_operand(input int node);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && node > 0)
      return SEL_W'($urandom_range(WINDOW_INPUTS + ((node > 4) ? node - 4 : 0),
                                   WINDOW_INPUTS + node - 1));
    else if (r < 92)
      return SEL_W'($urandom_range(0, WINDOW_INPUTS + node - 1));
    else
      return SEL_W'($urandom_range(0, SEL_TOP));
  endfunction

  function automatic logic [GENE_W-1:0] rand_gene(input int node);
    return {rand_operand(node), rand_operand(node), FUNC_W'($urandom)};
  endfunction

  // output selector word, mostly on the deepest nodes
  function automatic logic [GENE_W-1:0] rand_select_word();
    logic [SEL_W-1:0] sel;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 60) sel = SEL_W'($urandom_range(VALUE_COUNT - 8, VALUE_COUNT - 1));
    else if (r < 90) sel = SEL_W'($urandom_range(0, VALUE_COUNT - 1));
    else sel = SEL_W'($urandom_range(VALUE_COUNT, SEL_TOP));
    return {(GENE_W-SEL_W)'($urandom), sel};
  endfunction

  // full chromosome plus output selector, in shuffled order
  task automatic load_chromosome();
    int order [NODE_COUNT+1];
    int j;
    int t;
    for (int k = 0; k <= NODE_COUNT; k++) order[k] = k;
    for (int k = NODE_COUNT; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k <= NODE_COUNT; k++) begin
      if (order[k] == NODE_COUNT) send_gene(ADDR_W'(NODE_COUNT), rand_select_word());
      else send_gene(ADDR_W'(order[k]), rand_gene(order[k]));
    end
  endtask

  // stimulus and verdict
  initial begin
    int               episode;
    int               windows;
    int               r;
    window_t          ramp;
    logic [SEL_W-1:0] sa;
    logic [SEL_W-1:0] sb;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_GENE;
    no_idle       = 1'b0;
    item_count    = 0;
    for (int k = 0; k < WINDOW_INPUTS; k++) ramp[k*PIXEL_W +: PIXEL_W] = PIXEL_W'(k * 28 + 3);
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // gene addresses past the output selector are dropped
    send_gene('1, '1);
    send_gene(ADDR_W'(NODE_COUNT + 1), '0);

    // directed chain: each function twice, plus self, forward and too-high selectors
    for (int n = 0; n < NODE_COUNT; n++) begin
      sa = (n == 0) ? SEL_W'(4) : SEL_W'(WINDOW_INPUTS + n - 1);
      sb = SEL_W'(n % WINDOW_INPUTS);
      if (n == 7) sa = SEL_W'(WINDOW_INPUTS + n);
      if (n == 12) sb = SEL_W'(WINDOW_INPUTS + 20);
      if (n == 20) sa = '1;
      send_gene(ADDR_W'(n), {sa, sb, FUNC_W'(n % 16)});
    end
    send_gene(ADDR_W'(NODE_COUNT), {{(GENE_W-SEL_W){1'b1}}, SEL_W'(VALUE_COUNT - 2)});
    send_window('0);
    send_window('1);
    send_window(ramp);
    send_window(rand_window());

    // output selector beyond the last node reads zero
    send_gene(ADDR_W'(NODE_COUNT), GENE_W'(SEL_TOP));
    send_window(ramp);
    send_gene(ADDR_W'(NODE_COUNT), GENE_W'(VALUE_COUNT));
    send_window('1);
    // output selector on the first and last pixels
    send_gene(ADDR_W'(NODE_COUNT), {{(GENE_W-SEL_W){1'b1}}, SEL_W'(0)});
    send_window(ramp);
    send_gene(ADDR_W'(NODE_COUNT), GENE_W'(WINDOW_INPUTS - 1));
    send_window(ramp);

    // random chromosomes, each followed by a run of windows
    item_count = 0;
    episode    = 0;
    while (item_count < RANDOM_ITEMS) begin
      no_idle = (episode >= 6 && episode < 9);
      if (episode % 10 == 3) begin
        @(negedge clk) s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      load_chromosome();
      windows = $urandom_range(10, 60);
      for (int k = 0; k < windows; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          windows = $urandom_range(0, NODE_COUNT - 1);
          send_gene(ADDR_W'(windows), rand_gene(windows));
          windows = k + 1 + $urandom_range(5, 20);
        end else if (r < 6) send_gene(ADDR_W'(NODE_COUNT), rand_select_word());
        else if (r < 8) begin
          send_gene(ADDR_W'($urandom_range(NODE_COUNT + 1, SEL_TOP)), GENE_W'($urandom));
        end else send_window(rand_window());
      end
      episode++;
    end
    no_idle = 1'b0;

    // drain
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("cgp_window_filter_eval test passed");
    end else begin
      $display("cgp_window_filter_eval test failed");
    end
    $finish;
  end

endmodule
